### sv/imm_pkg.sv
// Shared types and constants for the integer matrix multiply core.
package imm_pkg;

  // Defaults for the top-level parameters.
  localparam int DEFAULT_MAX_DIM      = 8;
  localparam int DEFAULT_ELEMENT_BITS = 16;

  // Configuration port.
  localparam int CFG_BITS       = 4;
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROWS_OF_A  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INNER_SIZE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COLS_OF_B  = 2'd2;
  localparam logic [CFG_BITS-1:0]       CFG_DIM_RESET  = 4'd8;

  // Effective dimension, 1..MAX_DIM.
  localparam int DIM_W = 5;

  // Result word.
  localparam int TAG_BITS    = 3;
  localparam int RESULT_BITS = 32;

  // Depth of the queue between the load front and the compute back.
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] inner;
    logic [DIM_W-1:0] cols;
  } imm_dims_t;

endpackage

### sv/imm_front.sv
// Load front: tags each incoming element with its matrix, row and column.
module imm_front #(
  parameter int MAX_DIM      = imm_pkg::DEFAULT_MAX_DIM,
  parameter int ELEMENT_BITS = imm_pkg::DEFAULT_ELEMENT_BITS,
  parameter int WORD_W       = 2 + 2 * $clog2(MAX_DIM) + ELEMENT_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           clear,
  input  imm_pkg::imm_dims_t             dims,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [ELEMENT_BITS-1:0] in_element,
  output logic                           q_valid,
  input  logic                           q_ready,
  output logic [WORD_W-1:0]              q_word
);
  import imm_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIM);

  logic             is_b_r;
  logic [IDX_W-1:0] row_r;
  logic [IDX_W-1:0] col_r;
  logic [DIM_W-1:0] row_lim;
  logic [DIM_W-1:0] col_lim;
  logic             row_end;
  logic             col_end;
  logic             accept;

  // A is rows x inner, B is inner x cols.
  assign row_lim = is_b_r ? dims.inner : dims.rows;
  assign col_lim = is_b_r ? dims.cols  : dims.inner;
  assign row_end = (DIM_W'(row_r) == row_lim - DIM_W'(1));
  assign col_end = (DIM_W'(col_r) == col_lim - DIM_W'(1));

  assign accept   = in_valid && q_ready;
  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign q_word   = {is_b_r, is_b_r && row_end && col_end, row_r, col_r, in_element};

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      is_b_r <= 1'b0;
      row_r  <= '0;
      col_r  <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_r <= '0;
        if (row_end) begin
          row_r  <= '0;
          is_b_r <= !is_b_r;
        end else begin
          row_r <= row_r + IDX_W'(1);
        end
      end else begin
        col_r <= col_r + IDX_W'(1);
      end
    end
  end

endmodule

### sv/imm_queue.sv
// Short FIFO that decouples the load front from the compute back.
module imm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = imm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_word,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_word
);
  import imm_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != (PTR_W+1)'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_word  = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PTR_W+1)'(1);
      end
    end
  end

endmodule

### sv/imm_back.sv
// Compute back: stores both matrices, then runs a pipelined multiply-accumulate.
module imm_back #(
  parameter int MAX_DIM      = imm_pkg::DEFAULT_MAX_DIM,
  parameter int ELEMENT_BITS = imm_pkg::DEFAULT_ELEMENT_BITS,
  parameter int WORD_W       = 2 + 2 * $clog2(MAX_DIM) + ELEMENT_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  imm_pkg::imm_dims_t                    dims,
  input  logic                                  q_valid,
  output logic                                  q_ready,
  input  logic [WORD_W-1:0]                     q_word,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [imm_pkg::TAG_BITS-1:0]          out_row,
  output logic [imm_pkg::TAG_BITS-1:0]          out_col,
  output logic signed [imm_pkg::RESULT_BITS-1:0] out_product_value,
  output logic                                  out_last_of_matrix
);
  import imm_pkg::*;

  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  typedef enum logic {ST_LOAD, ST_CALC} state_t;

  state_t state_r;

  // Incoming word fields.
  logic [ELEMENT_BITS-1:0] w_val;
  logic [IDX_W-1:0]        w_col;
  logic [IDX_W-1:0]        w_row;
  logic                    w_last;
  logic                    w_is_b;

  logic [ELEMENT_BITS-1:0] left_mem  [MEM_DEPTH];
  logic [ELEMENT_BITS-1:0] right_mem [MEM_DEPTH];

  // Sequencer.
  logic [IDX_W-1:0] i_r;
  logic [IDX_W-1:0] j_r;
  logic [IDX_W-1:0] t_r;
  logic             i_end;
  logic             j_end;
  logic             t_end;
  logic             adv;
  logic             rd_en;

  // Stage 1: operands read.
  logic signed [ELEMENT_BITS-1:0] a_rd_r;
  logic signed [ELEMENT_BITS-1:0] b_rd_r;
  logic                           v1_r;
  logic                           first1_r;
  logic                           end1_r;
  logic                           lastm1_r;
  logic [IDX_W-1:0]               i1_r;
  logic [IDX_W-1:0]               j1_r;

  // Stage 2: product.
  logic signed [RESULT_BITS-1:0] a_ext;
  logic signed [RESULT_BITS-1:0] b_ext;
  logic signed [RESULT_BITS-1:0] prod_r;
  logic                          v2_r;
  logic                          first2_r;
  logic                          end2_r;
  logic                          lastm2_r;
  logic [IDX_W-1:0]              i2_r;
  logic [IDX_W-1:0]              j2_r;

  // Stage 3: accumulate and output.
  logic signed [RESULT_BITS-1:0] acc_r;
  logic signed [RESULT_BITS-1:0] sum;
  logic                          out_valid_r;
  logic [TAG_BITS-1:0]           out_row_r;
  logic [TAG_BITS-1:0]           out_col_r;
  logic signed [RESULT_BITS-1:0] out_value_r;
  logic                          out_last_r;

  assign {w_is_b, w_last, w_row, w_col, w_val} = q_word;

  assign q_ready = (state_r == ST_LOAD);
  assign adv     = !(out_valid_r && !out_ready);
  assign rd_en   = (state_r == ST_CALC) && adv;

  assign i_end = (DIM_W'(i_r) == dims.rows  - DIM_W'(1));
  assign j_end = (DIM_W'(j_r) == dims.cols  - DIM_W'(1));
  assign t_end = (DIM_W'(t_r) == dims.inner - DIM_W'(1));

  assign a_ext = RESULT_BITS'(a_rd_r);
  assign b_ext = RESULT_BITS'(b_rd_r);
  assign sum   = first2_r ? prod_r : acc_r + prod_r;

  assign out_valid          = out_valid_r;
  assign out_row            = out_row_r;
  assign out_col            = out_col_r;
  assign out_product_value  = out_value_r;
  assign out_last_of_matrix = out_last_r;

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      if (w_is_b) begin
        right_mem[{w_row, w_col}] <= w_val;
      end else begin
        left_mem[{w_row, w_col}] <= w_val;
      end
    end
    if (rd_en) begin
      a_rd_r <= left_mem[{i_r, t_r}];
      b_rd_r <= right_mem[{t_r, j_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      i_r         <= '0;
      j_r         <= '0;
      t_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (q_valid && w_last) begin
            state_r <= ST_CALC;
            i_r     <= '0;
            j_r     <= '0;
            t_r     <= '0;
          end
        end
        ST_CALC: begin
          if (adv) begin
            if (t_end) begin
              t_r <= '0;
              if (j_end) begin
                j_r <= '0;
                if (i_end) begin
                  state_r <= ST_LOAD;
                end else begin
                  i_r <= i_r + IDX_W'(1);
                end
              end else begin
                j_r <= j_r + IDX_W'(1);
              end
            end else begin
              t_r <= t_r + IDX_W'(1);
            end
          end
        end
      endcase

      if (adv) begin
        v1_r     <= rd_en;
        first1_r <= (t_r == '0);
        end1_r   <= t_end;
        lastm1_r <= i_end && j_end;
        i1_r     <= i_r;
        j1_r     <= j_r;

        v2_r     <= v1_r;
        first2_r <= first1_r;
        end2_r   <= end1_r;
        lastm2_r <= lastm1_r;
        i2_r     <= i1_r;
        j2_r     <= j1_r;
        prod_r   <= a_ext * b_ext;

        if (v2_r) begin
          acc_r <= sum;
        end
      end

      if (adv && v2_r && end2_r) begin
        out_valid_r <= 1'b1;
        out_row_r   <= TAG_BITS'(i2_r);
        out_col_r   <= TAG_BITS'(j2_r);
        out_value_r <= sum;
        out_last_r  <= lastm2_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### sv/integer_matrix_multiply_core.sv
// Top level: signed integer matrix product C = A * B over streamed elements.
//
// Usage:
//   Set rows_of_a, inner_size and cols_of_b through cfg_we/cfg_index/cfg_data
//   while the block is idle (a zero reads as 1, anything above MAX_DIM as
//   MAX_DIM). Any write to one of these restarts the load at the first
//   element of A. Then stream elements on in_valid/in_ready: all of A in
//   row-major order, then all of B in row-major order, one word per cycle
//   while in_ready is high. The word that completes B starts the product;
//   C leaves on out_valid/out_ready in row-major order, each word tagged
//   with its row and column, and out_last_of_matrix marks the final one.
// Flow:
//   The multiply-accumulate unit handles one product term per cycle while
//   the receiver is not stalling it. The four-deep queue takes up to four
//   words of the next pair meanwhile, then in_ready drops.
// Reset puts all three dimensions at 8 and clears the load position; the
// element stores are not cleared. A stalled receiver holds the result
// register and freezes the multiply-accumulate pipeline until it drains.
module integer_matrix_multiply_core #(
  parameter int MAX_DIM      = imm_pkg::DEFAULT_MAX_DIM,
  parameter int ELEMENT_BITS = imm_pkg::DEFAULT_ELEMENT_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ELEMENT_BITS-1:0]         in_element,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [imm_pkg::TAG_BITS-1:0]           out_row,
  output logic [imm_pkg::TAG_BITS-1:0]           out_col,
  output logic signed [imm_pkg::RESULT_BITS-1:0] out_product_value,
  output logic                                   out_last_of_matrix,
  input  logic                                   cfg_we,
  input  logic [imm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [imm_pkg::CFG_BITS-1:0]           cfg_data
);
  import imm_pkg::*;

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int WORD_W = 2 + 2 * IDX_W + ELEMENT_BITS;

  logic [CFG_BITS-1:0] rows_r;
  logic [CFG_BITS-1:0] inner_r;
  logic [CFG_BITS-1:0] cols_r;
  logic                cfg_hit;
  imm_dims_t           dims;

  logic              fq_valid;
  logic              fq_ready;
  logic [WORD_W-1:0] fq_word;
  logic              qb_valid;
  logic              qb_ready;
  logic [WORD_W-1:0] qb_word;

  // Saturate a raw register value into the usable dimension range.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_BITS-1:0] v);
    logic [DIM_W-1:0] d;
    d = DIM_W'(v);
    if (d == '0) begin
      return DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return d;
  endfunction

  always_comb begin
    dims.rows  = eff_dim(rows_r);
    dims.inner = eff_dim(inner_r);
    dims.cols  = eff_dim(cols_r);
  end

  // Only a write to a real register restarts the load.
  assign cfg_hit = cfg_we && (cfg_index == CFG_ROWS_OF_A || cfg_index == CFG_INNER_SIZE ||
                              cfg_index == CFG_COLS_OF_B);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= CFG_DIM_RESET;
      inner_r <= CFG_DIM_RESET;
      cols_r  <= CFG_DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_OF_A:  rows_r  <= cfg_data;
        CFG_INNER_SIZE: inner_r <= cfg_data;
        CFG_COLS_OF_B:  cols_r  <= cfg_data;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  imm_front #(
    .MAX_DIM      (MAX_DIM),
    .ELEMENT_BITS (ELEMENT_BITS),
    .WORD_W       (WORD_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (cfg_hit),
    .dims       (dims),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_element (in_element),
    .q_valid    (fq_valid),
    .q_ready    (fq_ready),
    .q_word     (fq_word)
  );

  imm_queue #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_word  (fq_word),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_word  (qb_word)
  );

  imm_back #(
    .MAX_DIM      (MAX_DIM),
    .ELEMENT_BITS (ELEMENT_BITS),
    .WORD_W       (WORD_W)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .dims               (dims),
    .q_valid            (qb_valid),
    .q_ready            (qb_ready),
    .q_word             (qb_word),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_row            (out_row),
    .out_col            (out_col),
    .out_product_value  (out_product_value),
    .out_last_of_matrix (out_last_of_matrix)
  );

endmodule

### sim/imm_product_checker.sv
// Product checker for the integer matrix multiply core: predicts C from the loaded words.
module imm_product_checker #(
  parameter int MAX_DIM = imm_pkg::DEFAULT_MAX_DIM,
  parameter int EB      = imm_pkg::DEFAULT_ELEMENT_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic signed [EB-1:0]                   in_element,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic [imm_pkg::TAG_BITS-1:0]           out_row,
  input  logic [imm_pkg::TAG_BITS-1:0]           out_col,
  input  logic signed [imm_pkg::RESULT_BITS-1:0] out_product_value,
  input  logic                                   out_last_of_matrix,
  input  logic                                   cfg_we,
  input  logic [imm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [imm_pkg::CFG_BITS-1:0]           cfg_data,
  output int                                     mismatch_count,
  output int                                     products_pending,
  output int                                     products_checked
);

  localparam int PRINT_CAP = 30;

  typedef struct {
    logic [imm_pkg::TAG_BITS-1:0]    row;
    logic [imm_pkg::TAG_BITS-1:0]    col;
    logic [imm_pkg::RESULT_BITS-1:0] value;
    logic                            last;
  } product_word_t;

  logic [imm_pkg::CFG_BITS-1:0] rows_code, inner_code, cols_code;
  logic signed [EB-1:0]         left_mat  [MAX_DIM*MAX_DIM];
  logic signed [EB-1:0]         right_mat [MAX_DIM*MAX_DIM];
  int unsigned                  words_loaded;
  product_word_t                expected_products [$];

  initial begin
    mismatch_count   = 0;
    products_pending = 0;
    products_checked = 0;
  end

  // Zero reads as one, anything above the array size saturates.
  function automatic int unsigned used_dim(input logic [imm_pkg::CFG_BITS-1:0] code);
    if (code == 0) return 1;
    if (code > MAX_DIM) return MAX_DIM;
    return code;
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("MISMATCH %s at product word %0d: got 0x%0h, expected 0x%0h",
               field, products_checked, got, want);
    mismatch_count++;
  endtask

  // Store one element of A or B; the word that completes B yields all of C.
  task automatic load_and_multiply(input logic signed [EB-1:0] element);
    int unsigned   r, k, c, size_a, idx, i, j, t;
    int            acc;
    product_word_t w;
    r      = used_dim(rows_code);
    k      = used_dim(inner_code);
    c      = used_dim(cols_code);
    size_a = r * k;
    if (words_loaded < size_a) begin
      left_mat[(words_loaded / k) * MAX_DIM + words_loaded % k] = element;
    end else begin
      idx = words_loaded - size_a;
      right_mat[(idx / c) * MAX_DIM + idx % c] = element;
    end
    words_loaded++;
    if (words_loaded == size_a + k * c) begin
      words_loaded = 0;
      for (i = 0; i < r; i++) begin
        for (j = 0; j < c; j++) begin
          acc = 0;
          for (t = 0; t < k; t++)
            acc += int'(left_mat[i*MAX_DIM + t]) * int'(right_mat[t*MAX_DIM + j]);
          w.row   = i[imm_pkg::TAG_BITS-1:0];
          w.col   = j[imm_pkg::TAG_BITS-1:0];
          w.value = acc;
          w.last  = (i == r - 1) && (j == c - 1);
          expected_products.push_back(w);
        end
      end
    end
  endtask

  task automatic compare_product();
    product_word_t w;
    if (expected_products.size() == 0) begin
      flag_mismatch("unexpected word", out_product_value, 0);
    end else begin
      w = expected_products.pop_front();
      if (out_row !== w.row) flag_mismatch("row", out_row, w.row);
      if (out_col !== w.col) flag_mismatch("col", out_col, w.col);
      if (out_product_value !== w.value) flag_mismatch("value", out_product_value, w.value);
      if (out_last_of_matrix !== w.last) flag_mismatch("last", out_last_of_matrix, w.last);
    end
    products_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rows_code    = imm_pkg::CFG_DIM_RESET;
      inner_code   = imm_pkg::CFG_DIM_RESET;
      cols_code    = imm_pkg::CFG_DIM_RESET;
      words_loaded = 0;
      expected_products.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          imm_pkg::CFG_ROWS_OF_A: begin
            rows_code    = cfg_data;
            words_loaded = 0;
          end
          imm_pkg::CFG_INNER_SIZE: begin
            inner_code   = cfg_data;
            words_loaded = 0;
          end
          imm_pkg::CFG_COLS_OF_B: begin
            cols_code    = cfg_data;
            words_loaded = 0;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) load_and_multiply(in_element);
      if (out_valid && out_ready) compare_product();
    end
    products_pending = expected_products.size();
  end

endmodule

### sim/tb_top.sv
// Testbench top for the integer matrix multiply core: stimulus, flow control and verdict.
module tb_top;

  localparam int EB             = imm_pkg::DEFAULT_ELEMENT_BITS;
  localparam int MAX_DIM        = imm_pkg::DEFAULT_MAX_DIM;
  localparam int IDLE_PCT       = 19;
  localparam int HOLD_CYCLES    = 300;
  // Longest quiet spell in a correct run is the receiver hold-off; allow ten times that.
  localparam int WATCHDOG_LIMIT = 3000;
  // Queue depth plus the widest multiply-accumulate latency, with margin.
  localparam int SETTLE_CYCLES  = 24;
  localparam int RANDOM_ITEMS   = 120;

  logic                                   clk = 1'b0;
  logic                                   rst_n = 1'b0;
  logic                                   in_valid = 1'b0;
  logic                                   in_ready;
  logic signed [EB-1:0]                   in_element = '0;
  logic                                   out_valid;
  logic                                   out_ready = 1'b0;
  logic [imm_pkg::TAG_BITS-1:0]           out_row;
  logic [imm_pkg::TAG_BITS-1:0]           out_col;
  logic signed [imm_pkg::RESULT_BITS-1:0] out_product_value;
  logic                                   out_last_of_matrix;
  logic                                   cfg_we = 1'b0;
  logic [imm_pkg::CFG_INDEX_BITS-1:0]     cfg_index = imm_pkg::CFG_ROWS_OF_A;
  logic [imm_pkg::CFG_BITS-1:0]           cfg_data = '0;

  int mismatch_count, products_pending, products_checked;

  // Words waiting to be offered on the input channel.
  logic [EB-1:0] element_q [$];

  // Flow-control knobs: random idling on both sides, and one long receiver hold-off.
  bit   idle_on  = 1'b1;
  logic stall_go = 1'b0;
  logic stall_rx = 1'b0;
  int   quiet_cycles = 0;

  // Dimension codes as last written, used only to size the stimulus.
  logic [imm_pkg::CFG_BITS-1:0] rows_set = imm_pkg::CFG_DIM_RESET;
  logic [imm_pkg::CFG_BITS-1:0] inner_set = imm_pkg::CFG_DIM_RESET;
  logic [imm_pkg::CFG_BITS-1:0] cols_set = imm_pkg::CFG_DIM_RESET;
  int   elements_sent = 0;
  int   settings_count = 0;

  always #4 clk = ~clk;

  integer_matrix_multiply_core #(
    .MAX_DIM      (MAX_DIM),
    .ELEMENT_BITS (EB)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_element         (in_element),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_row            (out_row),
    .out_col            (out_col),
    .out_product_value  (out_product_value),
    .out_last_of_matrix (out_last_of_matrix),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  imm_product_checker #(
    .MAX_DIM (MAX_DIM),
    .EB      (EB)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_element         (in_element),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_row            (out_row),
    .out_col            (out_col),
    .out_product_value  (out_product_value),
    .out_last_of_matrix (out_last_of_matrix),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatch_count     (mismatch_count),
    .products_pending   (products_pending),
    .products_checked   (products_checked)
  );

  // Sender: hold valid and the word until accepted; only then advance or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (element_q.size() != 0 && !(idle_on && $urandom_range(99) < IDLE_PCT)) begin
        in_valid   <= 1'b1;
        in_element <= element_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: drop ready at random, or for the whole hold-off window.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_rx) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  // Hold off the receiver once, long enough for the core to back up and stall its input.
  initial begin
    wait (stall_go);
    @(posedge clk);
    stall_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    stall_rx <= 1'b0;
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned clamp_dim(input logic [imm_pkg::CFG_BITS-1:0] code);
    if (code == 0) return 1;
    if (code > MAX_DIM) return MAX_DIM;
    return code;
  endfunction

  // Elements of A plus elements of B for the current setting.
  function automatic int unsigned pair_len();
    return clamp_dim(rows_set) * clamp_dim(inner_set)
         + clamp_dim(inner_set) * clamp_dim(cols_set);
  endfunction

  // Mostly small sizes; sometimes zero, exactly the maximum, or a saturating code.
  function automatic logic [imm_pkg::CFG_BITS-1:0] pick_dim_code();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 16) return $urandom_range(15, MAX_DIM + 1);
    if (roll < 22) return MAX_DIM;
    return $urandom_range(5, 1);
  endfunction

  // Bias toward the signed extremes so that sums overflow often.
  function automatic logic [EB-1:0] pick_element();
    case ($urandom_range(9))
      0:       return {1'b1, {(EB-1){1'b0}}};
      1:       return {1'b0, {(EB-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom_range((1 << EB) - 1);
    endcase
  endfunction

  // Write one register; return at a falling edge so that queue pushes never race the sender.
  task automatic write_reg(input logic [imm_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [imm_pkg::CFG_BITS-1:0] code);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= code;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      imm_pkg::CFG_ROWS_OF_A:  rows_set  = code;
      imm_pkg::CFG_INNER_SIZE: inner_set = code;
      imm_pkg::CFG_COLS_OF_B:  cols_set  = code;
      default: ;
    endcase
  endtask

  task automatic set_dims(input logic [imm_pkg::CFG_BITS-1:0] rows,
                          input logic [imm_pkg::CFG_BITS-1:0] inner,
                          input logic [imm_pkg::CFG_BITS-1:0] cols);
    write_reg(imm_pkg::CFG_ROWS_OF_A, rows);
    write_reg(imm_pkg::CFG_INNER_SIZE, inner);
    write_reg(imm_pkg::CFG_COLS_OF_B, cols);
    settings_count++;
  endtask

  task automatic queue_element(input logic [EB-1:0] value);
    element_q.push_back(value);
    elements_sent++;
  endtask

  task automatic queue_pairs(input int unsigned pairs);
    repeat (pairs * pair_len()) queue_element(pick_element());
  endtask

  // Wait until every word is accepted and every product has arrived, then let the core settle.
  task automatic drain();
    do @(negedge clk);
    while (element_q.size() != 0 || in_valid || products_pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int          random_start;
    int unsigned partial;
    logic [imm_pkg::CFG_INDEX_BITS-1:0] restart_idx;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // 1x1 by 1x1: the signed extremes and minus one squared.
    set_dims(4'd1, 4'd1, 4'd1);
    queue_element({1'b1, {(EB-1){1'b0}}});
    queue_element({1'b1, {(EB-1){1'b0}}});
    queue_element({1'b0, {(EB-1){1'b1}}});
    queue_element({1'b1, {(EB-1){1'b0}}});
    queue_element('1);
    queue_element('1);
    queue_element('0);
    queue_element({1'b0, {(EB-1){1'b1}}});
    drain();

    // Zero codes read as one.
    set_dims(4'd0, 4'd0, 4'd0);
    queue_element(16'h1234);
    queue_element(16'hfedc);
    drain();

    // Two most-negative products sum past the top of 32 bits and wrap.
    set_dims(4'd1, 4'd2, 4'd1);
    repeat (4) queue_element({1'b1, {(EB-1){1'b0}}});
    drain();

    // Abandon a load half way; a register write restarts it at the first element of A.
    queue_element({1'b0, {(EB-1){1'b1}}});
    queue_element({1'b0, {(EB-1){1'b1}}});
    queue_element(16'd1);
    drain();
    write_reg(imm_pkg::CFG_INNER_SIZE, 4'd2);
    queue_element(16'd3);
    queue_element(-16'sd5);
    queue_element(16'd7);
    queue_element(16'd11);
    drain();

    random_start = elements_sent;

    // Saturated rows and columns: 64 products per pair, with the receiver held off.
    set_dims(4'd15, 4'd1, 4'd12);
    stall_go = 1'b1;
    queue_pairs(2);
    drain();

    // Back-to-back words on both channels with no idling at all.
    idle_on = 1'b0;
    set_dims(4'd2, 4'd3, 4'd4);
    queue_pairs(2);
    drain();
    idle_on = 1'b1;

    // Random settings; now and then a broken load that a register write throws away.
    while (elements_sent - random_start < RANDOM_ITEMS) begin
      set_dims(pick_dim_code(), pick_dim_code(), pick_dim_code());
      if ($urandom_range(99) < 25) begin
        partial = $urandom_range(pair_len() - 1, 1);
        repeat (partial) queue_element(pick_element());
        drain();
        restart_idx = $urandom_range(2);
        write_reg(restart_idx, pick_dim_code());
      end
      queue_pairs($urandom_range(3, 1));
      drain();
    end

    $display("Covered %0d elements over %0d dimension settings, zero and saturated codes,",
             elements_sent, settings_count);
    $display("a mid-load restart and a %0d-cycle receiver hold-off; %0d product words checked.",
             HOLD_CYCLES, products_checked);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
